// ===== rtl/dpbht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbht_pkg
// Shared types and constants of the depth-preferred bucket hash table.
// ----------------------------------------------------------------------------
package dpbht_pkg;

  // field widths
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 32;
  localparam int BOUND_W = 2;
  localparam int MOVE_W  = 16;
  localparam int WAY_W   = 4;
  localparam int FUNC_W  = 2;

  // default geometry
  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;

  // stream payload widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;

  // one stored way
  typedef struct packed {
    logic [MOVE_W-1:0]         mv;
    logic [BOUND_W-1:0]        bound;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [KEY_W-1:0]          key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CLEAR
  } state_t;

  // way selection result
  typedef struct packed {
    logic             hit;
    logic             keep;
    logic [WAY_W-1:0] way;
  } sel_t;

endpackage

// ===== rtl/dpbht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbht_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dpbht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/dpbht_way_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbht_way_sel
// Compares a bucket row against a key and picks the way to report or write:
// first matching way, else first way of least depth.
// ----------------------------------------------------------------------------
module dpbht_way_sel #(
  parameter int WAYS = dpbht_pkg::WAYS_DEF
) (
  input  dpbht_pkg::entry_t [WAYS-1:0]   row,
  input  logic [dpbht_pkg::KEY_W-1:0]    key,
  input  logic [dpbht_pkg::DEPTH_W-1:0]  depth,
  output dpbht_pkg::sel_t                sel
);

  import dpbht_pkg::*;

  logic [WAYS-1:0]    match;
  logic [WAYS-1:0]    is_min;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   min_way;
  logic [DEPTH_W-1:0] hit_depth;

  // per-way key compare and least-depth flags
  always_comb begin
    match  = '0;
    is_min = '1;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (row[i].key == key);
      for (int j = 0; j < WAYS; j++) begin
        if (row[j].depth < row[i].depth) begin
          is_min[i] = 1'b0;
        end
      end
    end
  end

  // lowest-index priority over both flag sets
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    hit_depth = '0;
    min_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit       = 1'b1;
        hit_way   = WAY_W'(i);
        hit_depth = row[i].depth;
      end
      if (is_min[i]) begin
        min_way = WAY_W'(i);
      end
    end
  end

  // deeper stored result is kept
  always_comb begin
    sel.hit  = hit;
    sel.keep = hit && (depth < hit_depth);
    sel.way  = hit ? hit_way : min_way;
  end

endmodule

// ===== rtl/depth_preferred_bucket_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_preferred_bucket_hash_table
// Set-associative table of search results with depth-preferred replacement.
//
//   channel | dir | payload
//   in_     | in  | tdata: key, depth, score, bound_kind, best_move; tuser: func
//   out_    | out | tdata: way, depth_out, score_out, bound_out, move_out;
//           |     | tuser: found, written
//
// In a probe or store the accept cycle issues the registered bucket row read
// and the next cycle compares the ways. Once the output is free the result
// register is loaded and a store that does not keep the deeper entry writes
// the row back. A clear instead goes on to zero one row per cycle.
// After reset the same clearing pass runs over every row with in_tready low.
// A result waiting on out_tready holds the table in its compare cycle.
// The bucket index is the low bits of the key, so BUCKETS is a power of two.
// ----------------------------------------------------------------------------
module depth_preferred_bucket_hash_table #(
  parameter int BUCKETS = dpbht_pkg::BUCKETS_DEF,
  parameter int WAYS    = dpbht_pkg::WAYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key[63:0], depth[71:64], score[103:72], bound_kind[105:104],
  // best_move[121:106], zero fill above
  input  logic [dpbht_pkg::IN_DATA_W-1:0]     in_tdata,
  // func[1:0]
  input  logic [dpbht_pkg::FUNC_W-1:0]        in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // way[3:0], depth_out[11:4], score_out[43:12], bound_out[45:44],
  // move_out[61:46], zero fill above
  output logic [dpbht_pkg::OUT_DATA_W-1:0]    out_tdata,
  // found[0], written[1]
  output logic [dpbht_pkg::OUT_USER_W-1:0]    out_tuser
);

  import dpbht_pkg::*;

  localparam int BIDX_W = $clog2(BUCKETS);
  localparam int ROW_W  = WAYS * ENTRY_W;

  state_t               state_r, state_nxt;
  logic [BIDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // latched request
  op_t                  func_r;
  entry_t               req_r;

  // result register
  logic                 found_r;
  logic                 written_r;
  logic [WAY_W-1:0]     way_r;
  entry_t               res_r;

  // memory and selection signals
  logic                 rd_en;
  logic [ROW_W-1:0]     rd_data;
  entry_t [WAYS-1:0]    row_rd;
  entry_t [WAYS-1:0]    row_wr;
  logic                 wr_en;
  logic [BIDX_W-1:0]    wr_addr;
  logic [ROW_W-1:0]     wr_data;
  sel_t                 sel;
  entry_t               hit_ent;
  logic                 out_free;
  logic                 load_res;
  logic                 in_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign row_rd   = rd_data;
  assign rd_en    = in_fire;

  // bucket row memory
  dpbht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_tdata[BIDX_W-1:0]),
    .rd_data (rd_data)
  );

  // way compare and replacement choice
  dpbht_way_sel #(
    .WAYS (WAYS)
  ) u_way_sel (
    .row   (row_rd),
    .key   (req_r.key),
    .depth (req_r.depth),
    .sel   (sel)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_nxt = (func_r == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_r == BIDX_W'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // matched entry of the row
  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == sel.way) begin
        hit_ent = row_rd[i];
      end
    end
  end

  // row with the chosen way replaced
  always_comb begin
    row_wr = row_rd;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == sel.way) begin
        row_wr[i] = req_r;
      end
    end
  end

  // memory write, clear walk and result load
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = req_r.key[BIDX_W-1:0];
    wr_data     = row_wr;
    clr_cnt_nxt = clr_cnt_r;
    load_res    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_LOOK: begin
        load_res = out_free;
        wr_en    = out_free && (func_r == OP_STORE) && !sel.keep;
      end
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture on input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r       <= op_t'(in_tuser);
      req_r.key    <= in_tdata[63:0];
      req_r.depth  <= in_tdata[71:64];
      req_r.score  <= in_tdata[103:72];
      req_r.bound  <= in_tdata[105:104];
      req_r.mv     <= in_tdata[121:106];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_res) begin
      found_r   <= 1'b0;
      written_r <= 1'b0;
      way_r     <= '0;
      res_r     <= '0;
      case (func_r)
        OP_PROBE: begin
          if (sel.hit) begin
            found_r <= 1'b1;
            way_r   <= sel.way;
            res_r   <= hit_ent;
          end
        end
        OP_STORE: begin
          found_r   <= sel.hit;
          way_r     <= sel.way;
          written_r <= !sel.keep;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.mv, res_r.bound, res_r.score, res_r.depth, way_r};
  assign out_tuser  = {written_r, found_r};

  // only a store that does not keep the deeper entry writes in the compare cycle
  a_keep_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && func_r == OP_STORE && sel.keep) |-> !wr_en)
    else $error("row written although the stored entry is deeper");

  // a new result only comes out of the compare cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_LOOK)
    else $error("result loaded outside the compare cycle");

  // the clear walk starts at row zero
  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && state_nxt == ST_CLEAR) |=> clr_cnt_r == '0)
    else $error("clear walk does not start at row zero");

  // a result is never both a probe hit with data and a write
  a_probe_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && written_r) |-> (res_r == '0))
    else $error("store result carries entry data");

endmodule

// ===== verif/tb_depth_preferred_bucket_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_preferred_bucket_hash_table
// Self-checking bench for the depth-preferred bucket hash table. A mirror of
// the table predicts every probe, store, clear and idle operation as it is
// transferred in, and each result transfer is compared field by field with
// the oldest prediction. Traffic is a short directed set followed by random
// operations focused on a few crowded buckets, with random gaps and stalls
// on both streams, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_depth_preferred_bucket_hash_table;
  import dpbht_pkg::*;

  localparam int NUM_BUCKETS = BUCKETS_DEF;
  localparam int NUM_WAYS    = WAYS_DEF;
  localparam int NUM_ENTRIES = NUM_BUCKETS * NUM_WAYS;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int HOT_BUCKETS = 4;
  localparam int HOT_TAGS    = 8;

  // unused operation code, treated as no operation
  localparam logic [FUNC_W-1:0] OP_NOP = 2'd3;

  // one predicted result transfer
  typedef struct packed {
    logic                      found;
    logic [WAY_W-1:0]          way;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [MOVE_W-1:0]         mv;
    logic                      written;
  } table_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // mirror of the table contents
  logic [KEY_W-1:0]          mirror_key   [NUM_ENTRIES];
  logic [DEPTH_W-1:0]        mirror_depth [NUM_ENTRIES];
  logic signed [SCORE_W-1:0] mirror_score [NUM_ENTRIES];
  logic [BOUND_W-1:0]        mirror_bound [NUM_ENTRIES];
  logic [MOVE_W-1:0]         mirror_move  [NUM_ENTRIES];

  table_result_t    pending_results[$];
  logic [KEY_W-1:0] hot_keys[HOT_BUCKETS*HOT_TAGS];
  int               error_count;
  int               clears_left;
  int               sink_hold_len;
  bit               src_idle_en;
  bit               sink_idle_en;

  depth_preferred_bucket_hash_table #(
    .BUCKETS(NUM_BUCKETS),
    .WAYS   (NUM_WAYS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // mostly no gap, some short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // small depths collide often, so keeps and equal-depth overwrites happen
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int r;
    r = $urandom_range(9);
    if (r < 7) return DEPTH_W'($urandom_range(7));
    if (r < 9) return DEPTH_W'($urandom_range(255));
    return ($urandom_range(1) == 1) ? 8'hff : 8'h00;
  endfunction

  function automatic void wipe_mirror();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      mirror_key[i]   = '0;
      mirror_depth[i] = '0;
      mirror_score[i] = '0;
      mirror_bound[i] = '0;
      mirror_move[i]  = '0;
    end
  endfunction

  // crowded buckets: more keys per bucket than ways
  function automatic void refresh_hot_keys();
    logic [IDX_W-1:0]       bucket;
    logic [KEY_W-IDX_W-1:0] tag;
    for (int b = 0; b < HOT_BUCKETS; b++) begin
      case ($urandom_range(3))
        0:       bucket = '0;
        1:       bucket = '1;
        default: bucket = IDX_W'($urandom_range(NUM_BUCKETS - 1));
      endcase
      for (int t = 0; t < HOT_TAGS; t++) begin
        tag = (t == 0 && bucket == '0) ? '0 : (KEY_W-IDX_W)'(rand_key());
        hot_keys[b*HOT_TAGS + t] = {tag, bucket};
      end
    end
  endfunction

  // next state of the table and the result of one operation
  function automatic table_result_t predict_table_op(
    input logic [FUNC_W-1:0]        func,
    input logic [KEY_W-1:0]         key,
    input logic [DEPTH_W-1:0]       depth,
    input logic signed [SCORE_W-1:0] score,
    input logic [BOUND_W-1:0]       bound,
    input logic [MOVE_W-1:0]        mv
  );
    table_result_t      res;
    int                 base;
    int                 pick;
    int                 w;
    logic [DEPTH_W-1:0] least;
    bit                 hit;
    bit                 keep;
    res  = '0;
    base = int'(key[IDX_W-1:0]) * NUM_WAYS;
    hit  = 1'b0;
    keep = 1'b0;
    pick = 0;
    case (func)
      OP_PROBE: begin
        for (w = 0; w < NUM_WAYS; w++) begin
          if (!hit && mirror_key[base+w] == key) begin
            hit       = 1'b1;
            res.found = 1'b1;
            res.way   = WAY_W'(w);
            res.depth = mirror_depth[base+w];
            res.score = mirror_score[base+w];
            res.bound = mirror_bound[base+w];
            res.mv    = mirror_move[base+w];
          end
        end
      end
      OP_STORE: begin
        // first matching way, else first way of least depth
        least = mirror_depth[base];
        for (w = 0; w < NUM_WAYS; w++) begin
          if (!hit) begin
            if (mirror_key[base+w] == key) begin
              hit  = 1'b1;
              pick = w;
              keep = depth < mirror_depth[base+w];
            end else if (mirror_depth[base+w] < least) begin
              least = mirror_depth[base+w];
              pick  = w;
            end
          end
        end
        res.found = hit;
        res.way   = WAY_W'(pick);
        if (!keep) begin
          mirror_key[base+pick]   = key;
          mirror_depth[base+pick] = depth;
          mirror_score[base+pick] = score;
          mirror_bound[base+pick] = bound;
          mirror_move[base+pick]  = mv;
          res.written             = 1'b1;
        end
      end
      OP_CLEAR: wipe_mirror();
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 200)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input stream driver
  // ---------------------------------------------------------------------------

  // one input transfer; valid stays high until the next call or a drain
  task automatic send_item(
    input logic [FUNC_W-1:0]        func,
    input logic [KEY_W-1:0]         key,
    input logic [DEPTH_W-1:0]       depth,
    input logic signed [SCORE_W-1:0] score,
    input logic [BOUND_W-1:0]       bound,
    input logic [MOVE_W-1:0]        mv
  );
    int gap;
    gap = src_idle_en ? pick_idle() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {6'd0, mv, bound, score, depth, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_table_op(func, key, depth, score, bound, mv));
  endtask

  // random operation, mostly on crowded buckets
  task automatic send_random_op();
    int               r;
    logic [KEY_W-1:0] key;
    logic [FUNC_W-1:0] func;
    r   = $urandom_range(999);
    key = hot_keys[$urandom_range(HOT_BUCKETS*HOT_TAGS - 1)];
    if (r < 450) func = OP_STORE;
    else if (r < 800) func = OP_PROBE;
    else if (r < 860) begin
      func = OP_STORE;
      key  = rand_key();
    end else if (r < 920) begin
      func = OP_PROBE;
      key  = rand_key();
    end else if (r < 960) begin
      func = OP_NOP;
      key  = rand_key();
    end else if (r < 985) begin
      func = (r < 973) ? OP_PROBE : OP_STORE;
      key  = '0;
    end else if (clears_left > 0) begin
      func = OP_CLEAR;
      key  = rand_key();
      clears_left--;
    end else begin
      func = OP_PROBE;
    end
    send_item(func, key, pick_depth(), $urandom, BOUND_W'($urandom_range(3)),
              MOVE_W'($urandom_range(65535)));
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output stream: ready pattern and result check
  // ---------------------------------------------------------------------------

  // ready driver; a requested hold-off is counted down here
  initial begin : sink_ready_driver
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_len > 0) begin
        out_tready <= 1'b0;
        sink_hold_len--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (sink_idle_en) stall = pick_idle();
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.found)
          report_mismatch("found", out_tuser[0], want.found);
        if (out_tuser[1] !== want.written)
          report_mismatch("written", out_tuser[1], want.written);
        if (out_tdata[3:0] !== want.way)
          report_mismatch("way", out_tdata[3:0], want.way);
        if (out_tdata[11:4] !== want.depth)
          report_mismatch("depth_out", out_tdata[11:4], want.depth);
        if (out_tdata[43:12] !== want.score)
          report_mismatch("score_out", out_tdata[43:12], want.score);
        if (out_tdata[45:44] !== want.bound)
          report_mismatch("bound_out", out_tdata[45:44], want.bound);
        if (out_tdata[61:46] !== want.mv)
          report_mismatch("move_out", out_tdata[61:46], want.mv);
        if (out_tdata[63:62] !== 2'b00)
          report_mismatch("tdata fill", out_tdata[63:62], 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset leaves every way zeroed, so key 0 hits way 0
  task automatic test_cleared_table();
    send_item(OP_PROBE, '0, 8'd9, 32'sd5, 2'd1, 16'h1234);
    send_item(OP_PROBE, rand_key() | 64'h8000_0000_0000_0400, '0, '0, '0, '0);
  endtask

  // one bucket: keep on shallower store, overwrite on equal depth, fill and evict
  task automatic test_replacement();
    logic [KEY_W-1:0] ka, kb, kc, kd, ke;
    ka = {54'h0000_0000_0001, 10'd7};
    kb = {54'h2aaa_aaaa_aaaa, 10'd7};
    kc = {54'h1555_5555_5555, 10'd7};
    kd = {54'h3fff_ffff_fff0, 10'd7};
    ke = {54'h0123_4567_89ab, 10'd7};
    send_item(OP_STORE, ka, 8'd10, -32'sd77, 2'd1, 16'h00aa);
    send_item(OP_PROBE, ka, '0, '0, '0, '0);
    send_item(OP_STORE, ka, 8'd5, 32'sd1, 2'd2, 16'h5555);
    send_item(OP_STORE, ka, 8'd10, 32'sd2, 2'd0, 16'haaaa);
    send_item(OP_STORE, kb, 8'd3, 32'sd3, 2'd1, 16'h0003);
    send_item(OP_STORE, kc, 8'd3, 32'sd4, 2'd2, 16'h0004);
    send_item(OP_STORE, kd, 8'd1, 32'sd5, 2'd0, 16'h0005);
    send_item(OP_STORE, ke, 8'd2, 32'sd6, 2'd3, 16'h0006);
    send_item(OP_PROBE, kd, '0, '0, '0, '0);
    send_item(OP_PROBE, ke, '0, '0, '0, '0);
    send_item(OP_PROBE, ka, '0, '0, '0, '0);
  endtask

  // extreme field values, bound kind 3 stored as given
  task automatic test_field_extremes();
    send_item(OP_STORE, '1, 8'hff, 32'sh8000_0000, 2'd3, 16'hffff);
    send_item(OP_PROBE, '1, '0, '0, '0, '0);
    send_item(OP_STORE, {54'h1f0f_0f0f_0f0f, 10'h3ff}, 8'h00, 32'sh7fff_ffff, 2'd0, 16'h0000);
    send_item(OP_PROBE, {54'h1f0f_0f0f_0f0f, 10'h3ff}, '0, '0, '0, '0);
  endtask

  // unused code does nothing; clear empties the table
  task automatic test_clear_and_nop();
    send_item(OP_NOP, '1, 8'hff, -32'sd1, 2'd3, 16'hffff);
    send_item(OP_CLEAR, '1, 8'hff, -32'sd1, 2'd3, 16'hffff);
    send_item(OP_PROBE, {54'h0000_0000_0001, 10'd7}, '0, '0, '0, '0);
    send_item(OP_PROBE, '0, '0, '0, '0, '0);
    send_item(OP_STORE, '0, 8'd0, 32'sd42, 2'd2, 16'hbeef);
    send_item(OP_PROBE, '0, '0, '0, '0, '0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    src_idle_en   = 1'b0;
    sink_hold_len = 200;
    repeat (24) send_random_op();
    src_idle_en = 1'b1;
  endtask

  // sender pauses until the table has answered everything
  task automatic test_drain_pause();
    repeat (15) send_random_op();
    wait_drained();
    repeat (15) send_random_op();
  endtask

  task automatic test_random_traffic(input int count, input bit idle_on);
    src_idle_en  = idle_on;
    sink_idle_en = idle_on;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) refresh_hot_keys();
      send_random_op();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    error_count   = 0;
    clears_left   = 10;
    sink_hold_len = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    wipe_mirror();
    refresh_hot_keys();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cleared_table();
    test_replacement();
    test_field_extremes();
    test_clear_and_nop();
    test_random_traffic(300, 1'b1);
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic(120, 1'b0);
    test_random_traffic(460, 1'b1);

    wait_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
